/* hdl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/des_pkg.sv */
package des_pkg;

    localparam int NumRounds = 16;

    typedef logic [63:0] t_block;
    typedef logic [47:0] t_rkey;
    typedef logic [27:0] t_half;

    // data handed from one round cell to the next
    typedef struct packed {
        logic        valid;
        logic [31:0] left;
        logic [31:0] right;
    } t_round_bus;

    // generic msb-first permutation helpers
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [7:0] tbl [64];
        logic [63:0] r;
        tbl = '{8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
                8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
                8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,
                8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
                8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
                8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
                8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
                8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
        for (int i = 0; i < 64; i++) r[63-i] = x[64 - 32'(tbl[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [7:0] tbl [64];
        logic [63:0] r;
        tbl = '{8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,
                8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
                8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,
                8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
                8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,
                8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
                8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
                8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
        for (int i = 0; i < 64; i++) r[63-i] = x[64 - 32'(tbl[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [7:0] tbl [56];
        logic [55:0] r;
        tbl = '{8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,
                8'd26,8'd18,8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
                8'd60,8'd52,8'd44,8'd36,8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,
                8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,
                8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
        for (int i = 0; i < 56; i++) r[55-i] = x[64 - 32'(tbl[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [7:0] tbl [48];
        logic [47:0] r;
        tbl = '{8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
                8'd23,8'd19,8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
                8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
                8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};
        for (int i = 0; i < 48; i++) r[47-i] = x[56 - 32'(tbl[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_e(input logic [31:0] x);
        logic [7:0] tbl [48];
        logic [47:0] r;
        tbl = '{8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
                8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
                8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
                8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};
        for (int i = 0; i < 48; i++) r[47-i] = x[32 - 32'(tbl[i])];
        return r;
    endfunction

    function automatic logic [31:0] perm_p(input logic [31:0] x);
        logic [7:0] tbl [32];
        logic [31:0] r;
        tbl = '{8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,
                8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
                8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,
                8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};
        for (int i = 0; i < 32; i++) r[31-i] = x[32 - 32'(tbl[i])];
        return r;
    endfunction

    // s-box lookup, box 0..7, six input bits in des order
    function automatic logic [3:0] sbox(input logic [2:0] box, input logic [5:0] six);
        logic [3:0] s [8][64];
        logic [5:0] idx;
        s[0] = '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,
                 4'd5,4'd9,4'd0,4'd7,4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,
                 4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,4'd4,4'd1,4'd14,4'd8,
                 4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
                 4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,
                 4'd10,4'd0,4'd6,4'd13};
        s[1] = '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,
                 4'd12,4'd0,4'd5,4'd10,4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,
                 4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,4'd0,4'd14,4'd7,4'd11,
                 4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
                 4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,
                 4'd0,4'd5,4'd14,4'd9};
        s[2] = '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,
                 4'd11,4'd4,4'd2,4'd8,4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,
                 4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,4'd13,4'd6,4'd4,4'd9,
                 4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
                 4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,
                 4'd11,4'd5,4'd2,4'd12};
        s[3] = '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,
                 4'd11,4'd12,4'd4,4'd15,4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,
                 4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,4'd10,4'd6,4'd9,4'd0,
                 4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
                 4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,
                 4'd12,4'd7,4'd2,4'd14};
        s[4] = '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,
                 4'd13,4'd0,4'd14,4'd9,4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,
                 4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,4'd4,4'd2,4'd1,4'd11,
                 4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
                 4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,
                 4'd10,4'd4,4'd5,4'd3};
        s[5] = '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,
                 4'd14,4'd7,4'd5,4'd11,4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,
                 4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,4'd9,4'd14,4'd15,4'd5,
                 4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
                 4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,
                 4'd6,4'd0,4'd8,4'd13};
        s[6] = '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,
                 4'd5,4'd10,4'd6,4'd1,4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,
                 4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,4'd1,4'd4,4'd11,4'd13,
                 4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
                 4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,
                 4'd14,4'd2,4'd3,4'd12};
        s[7] = '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,
                 4'd5,4'd0,4'd12,4'd7,4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,
                 4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,4'd7,4'd11,4'd4,4'd1,
                 4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
                 4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,
                 4'd3,4'd5,4'd6,4'd11};
        idx = {six[5], six[0], six[4:1]};
        return s[box][idx];
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input t_rkey k);
        logic [47:0] x;
        logic [31:0] o;
        x = perm_e(r) ^ k;
        for (int b = 0; b < 8; b++) o[31-4*b -: 4] = sbox(3'(b), x[47-6*b -: 6]);
        return perm_p(o);
    endfunction

endpackage

/* hdl/des_round.sv */
module des_round
    import des_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_round_bus i_bus,
    input  t_rkey      i_rkey,
    output t_round_bus o_bus
);
    t_round_bus r_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.left  <= i_bus.right;
        r_bus.right <= i_bus.left ^ feistel(i_bus.right, i_rkey);
    end

    assign o_bus = r_bus;
endmodule

/* hdl/des_key_sched.sv */
module des_key_sched
    import des_pkg::*;
(
    input  logic   [63:0] i_key,
    input  logic          i_decrypt,
    output t_rkey         o_rkeys [NumRounds]
);
    // cumulative left rotation per round
    localparam int RotSum [NumRounds] =
        '{1, 2, 4, 6, 8, 10, 12, 14, 15, 17, 19, 21, 23, 25, 27, 28};

    logic [55:0] cd;
    t_half       c0, d0;
    t_rkey       rk [NumRounds];

    always_comb begin
        cd = perm_pc1(i_key);
        c0 = cd[55:28];
        d0 = cd[27:0];
        for (int i = 0; i < NumRounds; i++) begin
            t_half c, d;
            c = 28'((({c0, c0}) << RotSum[i]) >> 28);
            d = 28'((({d0, d0}) << RotSum[i]) >> 28);
            rk[i] = perm_pc2({c, d});
        end
        for (int i = 0; i < NumRounds; i++) begin
            o_rkeys[i] = i_decrypt ? rk[NumRounds-1-i] : rk[i];
        end
    end
endmodule

/* hdl/des_block_cipher_unit.sv */
// channel  | direction | signals                          | transfer when
// ---------+-----------+----------------------------------+------------------------
// data in  | input     | i_start, o_busy, i_data_block    | i_start & !o_busy
// data out | output    | o_result_valid, o_result_block   | o_result_valid (1 cycle)
// config   | input     | i_cfg_valid/ready, index, data   | i_cfg_valid & o_cfg_ready
//
// a block enters every cycle; its result passes, in order, through:
// input register, 16 round cells, output register (ip/fp are wiring)
// o_busy is always low, the round chain never stalls
// synchronous active-low reset clears key, mode and all valid bits
// round keys are wiring from the key register, so the user must change config
// only when idle; the block itself does not enforce it
`include "assert_macros.svh"
module des_block_cipher_unit
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_data_block,
    output logic        o_result_valid,
    output logic [63:0] o_result_block,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam logic [0:0] RegKey  = 1'b0;
    localparam logic [0:0] RegMode = 1'b1;

    logic [63:0] r_key;
    logic        r_mode;
    t_rkey       rkeys [NumRounds];
    t_round_bus  bus [NumRounds+1];
    t_round_bus  r_in;
    logic        r_out_valid;
    logic [63:0] r_out_block;
    logic [63:0] ip_blk;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegKey:  r_key  <= i_cfg_data;
                RegMode: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    des_key_sched u_keys (
        .i_key     (r_key),
        .i_decrypt (r_mode),
        .o_rkeys   (rkeys)
    );

    // input register after initial permutation
    assign ip_blk = perm_ip(i_data_block);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= i_start;
        end
        r_in.left  <= ip_blk[63:32];
        r_in.right <= ip_blk[31:0];
    end
    assign bus[0] = r_in;

    // chain of round cells
    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        des_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (bus[g]),
            .i_rkey  (rkeys[g]),
            .o_bus   (bus[g+1])
        );
    end

    // swap halves and final permutation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= bus[NumRounds].valid;
        end
        r_out_block <= perm_fp({bus[NumRounds].right, bus[NumRounds].left});
    end

    assign o_result_valid = r_out_valid;
    assign o_result_block = r_out_block;

    `ASSERT_CLK(a_lat, i_clk, i_rst_n, r_in.valid |=> bus[1].valid,
        "round chain lost a block")
    `ASSERT_CLK(a_out, i_clk, i_rst_n, bus[NumRounds].valid |=> o_result_valid,
        "output stage lost a block")
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_result_valid,
        "result strobe after reset")
endmodule
